FILE: hdl/variable_record_ring_buffer_assert.svh
// Assertion macros shared by the ring buffer RTL.
// Needs a clk and an arst_n in the scope of each use.
`ifndef VARIABLE_RECORD_RING_BUFFER_ASSERT_SVH
`define VARIABLE_RECORD_RING_BUFFER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define VRB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define VRB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define VRB_ASSERT(lbl, prop, msg)
`define VRB_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: hdl/vrb_pkg.sv
// Types, codes and helpers for the variable record ring buffer.
// No dependencies; used by vrb_datapath, vrb_ctrl and the top level.
package vrb_pkg;

	localparam int RING_WORDS_DEF = 256;
	localparam logic [15:0] TIMEOUT_RST = 16'd1000;

	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_PAYLOAD = 2'd1;
	localparam logic [1:0] OP_POP = 2'd2;
	localparam logic [1:0] OP_TICK = 2'd3;

	localparam logic [1:0] HS_FREE = 2'd0;
	localparam logic [1:0] HS_CLAIMED = 2'd1;
	localparam logic [1:0] HS_COMMITTED = 2'd2;

	typedef enum logic [2:0] {
		ST_ACCEPTED = 3'd0,
		ST_TOO_LARGE = 3'd1,
		ST_FULL = 3'd2,
		ST_DATA = 3'd3,
		ST_EMPTY = 3'd4,
		ST_BUSY = 3'd5,
		ST_STRAY = 3'd6
	} vrb_status_e;

	typedef enum logic [3:0] {
		S_IDLE, S_START, S_PAY, S_COMMIT, S_POP, S_EVAL, S_REC0, S_BUSY, S_DRD, S_DOUT
	} vrb_state_e;

	typedef struct packed {
		logic [1:0] cmd;
		logic [8:0] record_bytes;
		logic [63:0] data;
	} in_item_t;

	typedef struct packed {
		logic [2:0] status;
		logic [63:0] data_out;
		logic [8:0] payload_bytes;
		logic [31:0] sequence_res;
		logic last;
		logic [31:0] dropped_count;
		logic [31:0] poisoned_count;
	} out_item_t;

	typedef struct packed {
		logic cap_in;
		logic close_open;
		logic start_pad;
		logic start_claim;
		logic pay_wr;
		logic pay_commit;
		logic pop_rd;
		logic pop_clear;
		logic pop_adv_rec;
		logic pop_adv_one;
		logic pop_load;
		logic poison;
		logic data_rd;
		logic data_next;
		logic emit;
		vrb_status_e emit_status;
		logic emit_data;
		logic emit_last;
		logic drop_inc;
	} vrb_cmd_t;

	typedef struct packed {
		logic [1:0] in_op;
		logic oversize;
		logic nofit;
		logic needs_pad;
		logic open;
		logic pay_last;
		logic used_zero;
		logic [1:0] hdr_state;
		logic hdr_pad;
		logic expired;
		logic n_zero;
		logic data_last;
		logic out_free;
	} vrb_sts_t;

	function automatic logic [63:0] make_header(logic [1:0] st, logic pad, logic [8:0] bytes,
			logic [8:0] stride, logic [31:0] seq);
		make_header = {seq, 3'b0, stride, 3'b0, bytes, 5'b0, pad, st};
	endfunction

	// keep only the valid bytes of a record's final word
	function automatic logic [63:0] tail_mask(logic [2:0] nb);
		logic [63:0] m;
		m = '1;
		if (nb != 3'd0)
			m = ~(64'hFFFF_FFFF_FFFF_FFFF << {nb, 3'b000});
		tail_mask = m;
	endfunction

endpackage

FILE: hdl/vrb_datapath.sv
// Datapath: ring memory, claim time memory, pointers, counters, output register.
// Depends on vrb_pkg and the assertion macro header; driven by vrb_ctrl commands.
`include "variable_record_ring_buffer_assert.svh"
module vrb_datapath import vrb_pkg::*; #(
	parameter int RING_WORDS = RING_WORDS_DEF
) (
	input logic clk,
	input logic arst_n,
	input in_item_t in_item,
	input logic cfg_we,
	input logic [15:0] cfg_wdata,
	input logic out_ready,
	output logic out_valid,
	output out_item_t out_item,
	input vrb_cmd_t cmd,
	output vrb_sts_t sts
);

	localparam int PW = $clog2(RING_WORDS);
	localparam int MAX_BYTES = (RING_WORDS / 4 - 1) * 8;
	localparam logic [PW+1:0] TWO_R = (PW+2)'(2 * RING_WORDS);
	localparam logic [PW+1:0] ONE_R = (PW+2)'(RING_WORDS);

	logic [63:0] ring_mem [RING_WORDS];
	logic [31:0] ct_mem [RING_WORDS];

	logic [1:0] op_q;
	logic [8:0] rb_q;
	logic [63:0] din_q;
	logic [PW:0] wp_q, rp_q;
	logic [31:0] seq_q, tick_q, drop_q, poison_q;
	logic [PW-1:0] ohp_q, rd_pos_q;
	logic [6:0] wr_q;
	logic [8:0] open_bytes_q, open_stride_q;
	logic [31:0] open_seq_q;
	logic [15:0] timeout_q;
	logic [63:0] rdata_q;
	logic [31:0] ct_q;
	logic [5:0] dcnt_q, dn_q;
	logic [8:0] pop_bytes_q;
	logic [31:0] pop_seq_q;
	logic out_valid_q;
	out_item_t out_q;

	function automatic logic [PW-1:0] pos_of(logic [PW:0] p);
		logic [PW+1:0] e;
		e = {1'b0, p};
		if (e >= ONE_R)
			e = e - ONE_R;
		pos_of = e[PW-1:0];
	endfunction

	function automatic logic [PW:0] advance(logic [PW:0] p, logic [PW:0] n);
		logic [PW+1:0] s;
		s = {1'b0, p} + {1'b0, n};
		if (s >= TWO_R)
			s = s - TWO_R;
		advance = s[PW:0];
	endfunction

	logic [PW+1:0] used_w;
	logic [PW:0] used;
	logic [9:0] words_w;
	logic [6:0] words;
	logic [8:0] stride;
	logic [PW-1:0] wpos_now;
	logic [PW+1:0] space_w;
	logic [PW:0] space;
	logic [PW+1:0] free_w;
	logic [PW+1:0] pay_t;
	logic [PW-1:0] pay_pos;
	logic [8:0] hs1, adj;
	logic [8:0] n_full;
	logic [5:0] n6;
	logic [PW+1:0] drd_t;
	logic [PW-1:0] drd_pos;
	logic [31:0] age;
	logic [31:0] drop_sat;

	always_comb begin
		if (wp_q >= rp_q)
			used_w = {1'b0, wp_q} - {1'b0, rp_q};
		else
			used_w = {1'b0, wp_q} + TWO_R - {1'b0, rp_q};
		used = used_w[PW:0];
		free_w = ONE_R - used_w;
		words_w = {1'b0, rb_q} + 10'd7;
		words = words_w[9:3];
		stride = {2'b0, words} + 9'd1;
		wpos_now = pos_of(wp_q);
		space_w = ONE_R - {2'b0, wpos_now};
		space = space_w[PW:0];
		pay_t = {2'b0, ohp_q} + (PW+2)'(open_stride_q) - (PW+2)'(wr_q);
		if (pay_t >= ONE_R)
			pay_t = pay_t - ONE_R;
		pay_pos = pay_t[PW-1:0];
		hs1 = (rdata_q[28:20] == 9'd0) ? 9'd1 : rdata_q[28:20];
		adj = ({1'b0, hs1} > 10'(used)) ? 9'(used) : hs1;
		n_full = adj - 9'd1;
		n6 = (n_full > 9'd63) ? 6'd63 : n_full[5:0];
		drd_t = {2'b0, rd_pos_q} + (PW+2)'(1) + (PW+2)'(dcnt_q);
		if (drd_t >= ONE_R)
			drd_t = drd_t - ONE_R;
		drd_pos = drd_t[PW-1:0];
		age = tick_q - ct_q;
		drop_sat = (drop_q == '1) ? drop_q : drop_q + 32'd1;
	end

	always_comb begin
		sts.in_op = in_item.cmd;
		sts.oversize = (32'(rb_q) > 32'(MAX_BYTES));
		sts.nofit = ({1'b0, stride} > 10'(free_w));
		sts.needs_pad = ({1'b0, stride} > 10'(space_w));
		sts.open = (wr_q != 7'd0);
		sts.pay_last = (wr_q == 7'd1);
		sts.used_zero = (used == '0);
		sts.hdr_state = rdata_q[1:0];
		sts.hdr_pad = rdata_q[2];
		sts.expired = (age >= {16'b0, timeout_q});
		sts.n_zero = (n6 == 6'd0);
		sts.data_last = (dcnt_q == dn_q - 6'd1);
		sts.out_free = !out_valid_q || out_ready;
	end

	// single write port, single registered read port on the ring
	logic ring_we;
	logic [PW-1:0] ring_wa, ring_ra;
	logic [63:0] ring_wd;
	logic ring_re;

	always_comb begin
		ring_we = 1'b1;
		ring_wa = wpos_now;
		ring_wd = make_header(HS_COMMITTED, 1'b1, 9'd0, 9'(space), 32'd0);
		if (cmd.start_claim) begin
			ring_wd = make_header((words != 7'd0) ? HS_CLAIMED : HS_COMMITTED, 1'b0, rb_q,
				stride, seq_q + 32'd1);
		end else if (cmd.pay_wr) begin
			ring_wa = pay_pos;
			ring_wd = sts.pay_last ? (din_q & tail_mask(open_bytes_q[2:0])) : din_q;
		end else if (cmd.pay_commit) begin
			ring_wa = ohp_q;
			ring_wd = make_header(HS_COMMITTED, 1'b0, open_bytes_q, open_stride_q, open_seq_q);
		end else if (cmd.pop_clear) begin
			ring_wa = rd_pos_q;
			ring_wd = {rdata_q[63:2], 2'b00};
		end else if (!cmd.start_pad) begin
			ring_we = 1'b0;
		end
		ring_re = cmd.pop_rd || cmd.data_rd;
		ring_ra = cmd.pop_rd ? pos_of(rp_q) : drd_pos;
	end

	always_ff @(posedge clk) begin
		if (ring_we)
			ring_mem[ring_wa] <= ring_wd;
		if (cmd.start_claim)
			ct_mem[wpos_now] <= tick_q;
		if (ring_re)
			rdata_q <= ring_mem[ring_ra];
		if (cmd.pop_rd)
			ct_q <= ct_mem[ring_ra];
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_in) begin
			op_q <= in_item.cmd;
			rb_q <= in_item.record_bytes;
			din_q <= in_item.data;
		end
		if (cmd.pop_rd)
			rd_pos_q <= pos_of(rp_q);
		if (cmd.start_claim) begin
			ohp_q <= wpos_now;
			open_bytes_q <= rb_q;
			open_stride_q <= stride;
			open_seq_q <= seq_q + 32'd1;
		end
		if (cmd.pop_load) begin
			dn_q <= n6;
			pop_bytes_q <= rdata_q[16:8];
			pop_seq_q <= rdata_q[63:32];
		end
		if (cmd.pop_load)
			dcnt_q <= '0;
		else if (cmd.data_next)
			dcnt_q <= dcnt_q + 6'd1;
		if (cmd.emit) begin
			out_q.status <= cmd.emit_status;
			out_q.data_out <= cmd.emit_data ? rdata_q : 64'd0;
			out_q.payload_bytes <= (cmd.emit_status == ST_DATA) ? pop_bytes_q : 9'd0;
			unique case (cmd.emit_status)
				ST_ACCEPTED: out_q.sequence_res <= (op_q == OP_START) ? seq_q + 32'd1 : open_seq_q;
				ST_DATA: out_q.sequence_res <= pop_seq_q;
				default: out_q.sequence_res <= 32'd0;
			endcase
			out_q.last <= cmd.emit_last;
			out_q.dropped_count <= cmd.drop_inc ? drop_sat : drop_q;
			out_q.poisoned_count <= poison_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			seq_q <= '0;
			wr_q <= '0;
			tick_q <= '0;
			drop_q <= '0;
			poison_q <= '0;
			timeout_q <= TIMEOUT_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we)
				timeout_q <= cfg_wdata;
			if (cmd.cap_in && in_item.cmd == OP_TICK)
				tick_q <= tick_q + 32'd1;
			if (cmd.close_open)
				wr_q <= '0;
			if (cmd.start_pad)
				wp_q <= advance(wp_q, space);
			if (cmd.start_claim) begin
				wp_q <= advance(wp_q, stride[PW:0]);
				seq_q <= seq_q + 32'd1;
				wr_q <= words;
			end
			if (cmd.pay_wr)
				wr_q <= wr_q - 7'd1;
			if (cmd.pop_adv_rec)
				rp_q <= advance(rp_q, adj[PW:0]);
			else if (cmd.pop_adv_one)
				rp_q <= advance(rp_q, (PW+1)'(1));
			if (cmd.poison) begin
				poison_q <= (poison_q == '1) ? poison_q : poison_q + 32'd1;
				if (wr_q != 7'd0 && ohp_q == rd_pos_q)
					wr_q <= '0;
			end
			if (cmd.drop_inc)
				drop_q <= drop_sat;
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item = out_q;

	`VRB_ASSERT(a_used_bound, (used_w <= ONE_R), "ring occupancy above ring size")
	`VRB_ASSERT(a_ptr_range, ((wp_q < TWO_R[PW:0] || TWO_R[PW+1]) && (rp_q < TWO_R[PW:0] || TWO_R[PW+1])), "pointer out of range")
	`VRB_ASSERT_NEXT(a_open_bound, (wr_q != 7'd0), (wr_q <= 7'(open_stride_q)), "open word count beyond stride")

endmodule

FILE: hdl/vrb_ctrl.sv
// Controller state machine: sequences start, payload, pop and tick transactions.
// Depends on vrb_pkg and the assertion macro header; commands vrb_datapath.
`include "variable_record_ring_buffer_assert.svh"
module vrb_ctrl import vrb_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input vrb_sts_t sts,
	output vrb_cmd_t cmd
);

	vrb_state_e state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.emit_status = ST_ACCEPTED;
		cmd.emit_last = 1'b1;
		in_ready = (state_q == S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.cap_in = 1'b1;
					unique case (sts.in_op)
						OP_START: state_d = S_START;
						OP_PAYLOAD: state_d = S_PAY;
						OP_POP: state_d = S_POP;
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_START: begin
				if (sts.oversize || sts.nofit) begin
					if (sts.out_free) begin
						cmd.close_open = 1'b1;
						cmd.drop_inc = 1'b1;
						cmd.emit = 1'b1;
						cmd.emit_status = sts.oversize ? ST_TOO_LARGE : ST_FULL;
						state_d = S_IDLE;
					end
				end else if (sts.needs_pad) begin
					cmd.close_open = 1'b1;
					cmd.start_pad = 1'b1;
				end else if (sts.out_free) begin
					cmd.start_claim = 1'b1;
					cmd.emit = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_PAY: begin
				if (sts.out_free) begin
					if (!sts.open) begin
						cmd.emit = 1'b1;
						cmd.emit_status = ST_STRAY;
						state_d = S_IDLE;
					end else begin
						cmd.pay_wr = 1'b1;
						if (sts.pay_last) begin
							state_d = S_COMMIT;
						end else begin
							cmd.emit = 1'b1;
							state_d = S_IDLE;
						end
					end
				end
			end
			S_COMMIT: begin
				if (sts.out_free) begin
					cmd.pay_commit = 1'b1;
					cmd.emit = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_POP: begin
				if (sts.used_zero) begin
					if (sts.out_free) begin
						cmd.emit = 1'b1;
						cmd.emit_status = ST_EMPTY;
						state_d = S_IDLE;
					end
				end else begin
					cmd.pop_rd = 1'b1;
					state_d = S_EVAL;
				end
			end
			S_EVAL: begin
				case (sts.hdr_state)
					HS_COMMITTED: begin
						cmd.pop_clear = 1'b1;
						cmd.pop_adv_rec = 1'b1;
						if (sts.hdr_pad) begin
							state_d = S_POP;
						end else begin
							cmd.pop_load = 1'b1;
							state_d = sts.n_zero ? S_REC0 : S_DRD;
						end
					end
					HS_CLAIMED: begin
						if (sts.expired) begin
							cmd.pop_clear = 1'b1;
							cmd.pop_adv_rec = 1'b1;
							cmd.poison = 1'b1;
							state_d = S_POP;
						end else begin
							state_d = S_BUSY;
						end
					end
					default: begin
						cmd.pop_adv_one = 1'b1;
						state_d = S_POP;
					end
				endcase
			end
			S_REC0: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.emit_status = ST_DATA;
					state_d = S_IDLE;
				end
			end
			S_BUSY: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.emit_status = ST_BUSY;
					state_d = S_IDLE;
				end
			end
			S_DRD: begin
				cmd.data_rd = 1'b1;
				state_d = S_DOUT;
			end
			S_DOUT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.emit_status = ST_DATA;
					cmd.emit_data = 1'b1;
					cmd.emit_last = sts.data_last;
					cmd.data_next = 1'b1;
					state_d = sts.data_last ? S_IDLE : S_DRD;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	`VRB_ASSERT(a_emit_slot, (cmd.emit |-> sts.out_free), "result issued while output register full")
	`VRB_ASSERT_NEXT(a_accept_leaves_idle, (cmd.cap_in && sts.in_op != OP_TICK), (state_q != S_IDLE), "transaction dropped after accept")

endmodule

FILE: hdl/variable_record_ring_buffer.sv
// Variable-length record ring buffer: records of one header word plus payload words kept
// in a RING_WORDS-deep ring with one write port and one registered read port, with pad
// records at the wrap and timeout skipping. A start places a pad record first when the
// record does not fit before the ring end; the payload word that completes a record also
// commits its header. A pop visits headers in turn (ring read, then decode), then reads and
// emits each payload word, or reports busy, empty or a zero-byte record. Results wait in an
// output register, so input transactions keep flowing while the last result is still
// unclaimed; a state that has a result to issue waits while that register is full and
// out_ready is low.
// Depends on vrb_pkg, vrb_ctrl and vrb_datapath.
`include "variable_record_ring_buffer_assert.svh"
module variable_record_ring_buffer import vrb_pkg::*; #(
	parameter int RING_WORDS = RING_WORDS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input in_item_t in_item,
	output logic out_valid,
	input logic out_ready,
	output out_item_t out_item,
	input logic cfg_we,
	input logic [15:0] cfg_wdata
);

	vrb_cmd_t cmd;
	vrb_sts_t sts;

	vrb_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sts(sts),
		.cmd(cmd)
	);

	vrb_datapath #(.RING_WORDS(RING_WORDS)) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.in_item(in_item),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.out_ready(out_ready),
		.out_valid(out_valid),
		.out_item(out_item),
		.cmd(cmd),
		.sts(sts)
	);

	`VRB_ASSERT(a_status_code, (!out_valid || out_item.status != 3'd7), "unknown status code on output")

endmodule

FILE: dv/vrb_record_checker.sv
// Checker for the variable record ring buffer: watches both channels and the config port,
// predicts the result transactions of each input transaction and compares them in order.
// Depends on vrb_pkg for the payload struct types and status codes.
module vrb_record_checker import vrb_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input in_item_t in_item,
	input logic out_valid,
	input logic out_ready,
	input out_item_t out_item,
	input logic cfg_we,
	input logic [15:0] cfg_wdata,
	output int fail_count,
	output int results_owed
);

	localparam int WORDS = 256;
	localparam int MAX_REC_BYTES = (WORDS / 4 - 1) * 8;

	logic [63:0] ring[WORDS];
	logic [31:0] stamp[WORDS];
	logic [8:0] wr_ptr, rd_ptr;
	logic [31:0] seq_ctr, ticks, drops, poisons;
	logic [7:0] open_hdr;
	logic [6:0] words_left;
	logic [15:0] timeout;
	out_item_t owed_q[$];

	assign results_owed = owed_q.size();

	function automatic logic [31:0] bump(logic [31:0] c);
		return (c == '1) ? c : c + 1;
	endfunction

	function automatic logic [8:0] occupancy();
		return wr_ptr - rd_ptr;
	endfunction

	function automatic logic [63:0] hdr(logic [2:0] st, logic [8:0] bytes, logic [8:0] stride,
			logic [31:0] seq);
		hdr = '0;
		hdr[2:0] = st;
		hdr[16:8] = bytes;
		hdr[28:20] = stride;
		hdr[63:32] = seq;
	endfunction

	task automatic owe(vrb_status_e st, logic [63:0] d, logic [8:0] bytes, logic [31:0] seq,
			logic last);
		out_item_t r;
		r.status = st;
		r.data_out = d;
		r.payload_bytes = bytes;
		r.sequence_res = seq;
		r.last = last;
		r.dropped_count = drops;
		r.poisoned_count = poisons;
		owed_q.push_back(r);
	endtask

	task automatic predict_start(logic [8:0] rb);
		logic [8:0] nwords, stride, space;
		logic [7:0] pos;
		words_left = 0;
		if (rb > MAX_REC_BYTES) begin
			drops = bump(drops);
			owe(ST_TOO_LARGE, 0, 0, 0, 1);
			return;
		end
		nwords = (rb + 7) >> 3;
		stride = nwords + 1;
		for (int k = 0; k < 2; k++) begin
			if (stride > WORDS - occupancy()) begin
				drops = bump(drops);
				owe(ST_FULL, 0, 0, 0, 1);
				return;
			end
			pos = wr_ptr[7:0];
			space = WORDS - pos;
			if (stride <= space)
				break;
			// pad record fills the gap up to the ring end
			ring[pos] = hdr({1'b1, HS_COMMITTED}, 0, space, 0);
			wr_ptr = wr_ptr + space;
		end
		pos = wr_ptr[7:0];
		seq_ctr = seq_ctr + 1;
		ring[pos] = hdr({1'b0, (nwords != 0) ? HS_CLAIMED : HS_COMMITTED}, rb, stride, seq_ctr);
		stamp[pos] = ticks;
		wr_ptr = wr_ptr + stride;
		if (nwords != 0) begin
			open_hdr = pos;
			words_left = nwords;
		end
		owe(ST_ACCEPTED, 0, 0, seq_ctr, 1);
	endtask

	task automatic predict_payload(logic [63:0] d);
		logic [63:0] h;
		logic [7:0] wpos;
		if (words_left == 0) begin
			owe(ST_STRAY, 0, 0, 0, 1);
			return;
		end
		h = ring[open_hdr];
		wpos = open_hdr + h[28:20] - words_left;
		if (words_left == 1 && h[10:8] != 0)
			d = d & ~(64'hFFFF_FFFF_FFFF_FFFF << (8 * h[10:8]));
		ring[wpos] = d;
		words_left = words_left - 1;
		if (words_left == 0)
			ring[open_hdr] = {h[63:2], HS_COMMITTED};
		owe(ST_ACCEPTED, 0, 0, h[63:32], 1);
	endtask

	task automatic predict_pop();
		logic [63:0] h;
		logic [8:0] left, stride, n;
		logic [7:0] pos;
		for (int it = 0; it < 2 * WORDS + 2; it++) begin
			left = occupancy();
			if (left == 0)
				break;
			pos = rd_ptr[7:0];
			h = ring[pos];
			stride = h[28:20];
			if (stride == 0)
				stride = 1;
			if (stride > left)
				stride = left;
			if (h[1:0] == HS_COMMITTED) begin
				ring[pos] = {h[63:2], HS_FREE};
				rd_ptr = rd_ptr + stride;
				if (!h[2]) begin
					n = (stride - 1 > 63) ? 63 : stride - 1;
					if (n == 0)
						owe(ST_DATA, 0, h[16:8], h[63:32], 1);
					for (int i = 0; i < n; i++)
						owe(ST_DATA, ring[8'(pos + 1 + i)], h[16:8], h[63:32], i + 1 == n);
					return;
				end
			end else if (h[1:0] == HS_CLAIMED) begin
				if (ticks - stamp[pos] < {16'd0, timeout}) begin
					owe(ST_BUSY, 0, 0, 0, 1);
					return;
				end
				// timed out: skip it, closing it if it is the one being filled
				ring[pos] = {h[63:2], HS_FREE};
				if (words_left != 0 && open_hdr == pos)
					words_left = 0;
				rd_ptr = rd_ptr + stride;
				poisons = bump(poisons);
			end else begin
				rd_ptr = rd_ptr + 1;
			end
		end
		owe(ST_EMPTY, 0, 0, 0, 1);
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t exp_r;
		if (!arst_n) begin
			foreach (ring[i]) begin
				ring[i] = '0;
				stamp[i] = '0;
			end
			wr_ptr = 0;
			rd_ptr = 0;
			seq_ctr = 0;
			open_hdr = 0;
			words_left = 0;
			ticks = 0;
			drops = 0;
			poisons = 0;
			timeout = TIMEOUT_RST;
			owed_q.delete();
			fail_count = 0;
		end else begin
			if (cfg_we)
				timeout = cfg_wdata;
			if (out_valid && out_ready) begin
				if (owed_q.size() == 0) begin
					$display("%0t: unexpected result transaction %p", $time, out_item);
					fail_count++;
				end else begin
					exp_r = owed_q.pop_front();
					if (out_item.status !== exp_r.status) begin
						$display("%0t: status exp %0d got %0d", $time, exp_r.status,
							out_item.status);
						fail_count++;
					end
					if (out_item.data_out !== exp_r.data_out) begin
						$display("%0t: data_out exp %h got %h", $time, exp_r.data_out,
							out_item.data_out);
						fail_count++;
					end
					if (out_item.payload_bytes !== exp_r.payload_bytes) begin
						$display("%0t: payload_bytes exp %0d got %0d", $time,
							exp_r.payload_bytes, out_item.payload_bytes);
						fail_count++;
					end
					if (out_item.sequence_res !== exp_r.sequence_res) begin
						$display("%0t: sequence_res exp %0d got %0d", $time,
							exp_r.sequence_res, out_item.sequence_res);
						fail_count++;
					end
					if (out_item.last !== exp_r.last) begin
						$display("%0t: last exp %0d got %0d", $time, exp_r.last, out_item.last);
						fail_count++;
					end
					if (out_item.dropped_count !== exp_r.dropped_count) begin
						$display("%0t: dropped_count exp %0d got %0d", $time,
							exp_r.dropped_count, out_item.dropped_count);
						fail_count++;
					end
					if (out_item.poisoned_count !== exp_r.poisoned_count) begin
						$display("%0t: poisoned_count exp %0d got %0d", $time,
							exp_r.poisoned_count, out_item.poisoned_count);
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready) begin
				case (in_item.cmd)
					OP_START: predict_start(in_item.record_bytes);
					OP_PAYLOAD: predict_payload(in_item.data);
					OP_POP: predict_pop();
					default: ticks = ticks + 1;
				endcase
			end
		end
	end

endmodule

FILE: dv/tb_variable_record_ring_buffer.sv
// Testbench top for variable_record_ring_buffer: clock, reset, stimulus and verdict.
// Checking lives in vrb_record_checker; depends on vrb_pkg and the RTL.
module tb_variable_record_ring_buffer;
	import vrb_pkg::*;

	localparam int DRAIN_CYCLES = 1500;
	localparam int STALL_LIMIT = 6000;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	in_item_t in_item = '0;
	logic out_valid;
	logic out_ready = 0;
	out_item_t out_item;
	logic cfg_we = 0;
	logic [15:0] cfg_wdata = '0;
	int fail_count, results_owed;
	int sent = 0;
	int quiet_cycles = 0;

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	variable_record_ring_buffer dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	vrb_record_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.fail_count(fail_count), .results_owed(results_owed)
	);

	function automatic bit calm();
		return sent >= 250 && sent < 330;
	endfunction

	// one transaction on the input channel, with an optional random gap first
	task automatic offer(logic [1:0] cmd, logic [8:0] rb, logic [63:0] d);
		if (!calm() && $urandom_range(0, 99) < 31) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		in_valid <= 1;
		in_item <= '{cmd: cmd, record_bytes: rb, data: d};
		do @(posedge clk); while (!in_ready);
		sent++;
		@(negedge clk);
	endtask

	function automatic logic [63:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	task automatic write_record(logic [8:0] rb, int nwords);
		offer(OP_START, rb, rand_word());
		for (int i = 0; i < nwords; i++)
			offer(OP_PAYLOAD, 9'($urandom), rand_word());
	endtask

	task automatic settle();
		in_valid <= 0;
		while (results_owed != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic set_timeout(logic [15:0] v);
		cfg_we <= 1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 0;
	endtask

	function automatic logic [8:0] rand_bytes();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75)
			return 9'($urandom_range(0, 63));
		if (r < 95)
			return 9'($urandom_range(64, 504));
		return 9'($urandom_range(505, 511));
	endfunction

	task automatic random_phase(int n_items, int pop_pct);
		logic [8:0] rb;
		int r, target;
		target = sent + n_items;
		while (sent < target) begin
			r = $urandom_range(0, 99);
			rb = rand_bytes();
			if (r < pop_pct)
				offer(OP_POP, 9'($urandom), rand_word());
			else if (r < pop_pct + 45)
				write_record(rb, (rb + 7) / 8);
			else if (r < pop_pct + 55)
				write_record(rb, $urandom_range(0, (rb + 7) / 8));
			else if (r < pop_pct + 65)
				repeat ($urandom_range(1, 3)) offer(OP_TICK, 9'($urandom), rand_word());
			else if (r < pop_pct + 70)
				offer(OP_PAYLOAD, 9'($urandom), rand_word());
			else
				offer(OP_START, 9'($urandom_range(505, 511)), rand_word());
		end
	endtask

	// receiver: random stalls, one long hold-off while the sender keeps going
	initial begin
		bit held;
		held = 0;
		forever begin
			@(negedge clk);
			if (!held && sent >= 150) begin
				held = 1;
				out_ready <= 0;
				repeat (300) @(negedge clk);
			end
			out_ready <= (!calm() && $urandom_range(0, 99) < 31) ? 1'b0 : 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		repeat (3) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);
		// directed: empty record, extremes of size, tail bytes, stray, abandoned record
		write_record(0, 0);
		offer(OP_POP, 0, 0);
		offer(OP_POP, 0, 0);
		offer(OP_START, 505, 0);
		offer(OP_START, 511, '1);
		offer(OP_START, 504, 0);
		for (int i = 0; i < 63; i++)
			offer(OP_PAYLOAD, 0, (i % 2) ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h0);
		offer(OP_POP, 0, 0);
		write_record(13, 2);
		offer(OP_PAYLOAD, 9'h1FF, '1);
		offer(OP_POP, 0, 0);
		write_record(8, 0);
		offer(OP_POP, 0, 0);
		write_record(1, 1);
		offer(OP_TICK, 0, 0);
		offer(OP_POP, 0, 0);
		settle();
		set_timeout(16'hFFFF);
		random_phase(80, 5);
		settle();
		set_timeout(0);
		random_phase(80, 30);
		settle();
		set_timeout(6);
		random_phase(150, 30);
		settle();
		set_timeout(TIMEOUT_RST);
		random_phase(20, 30);
		settle();
		if (fail_count == 0 && results_owed == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
